// File: rtl/pcmu_pkg.sv
// package for the pcm sample word unpacker
// types, codes and helper functions shared by the front, queue, back and top
// no dependencies
package pcmu_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SIZE_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STEP_W    = 3;

  // sample_format codes
  localparam logic [1:0] FMT_16     = 2'd0;
  localparam logic [1:0] FMT_32     = 2'd1;
  localparam logic [1:0] FMT_PACKED = 2'd2;

  // data_size codes
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_16   = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_32   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK    = 3'd4;

  // final step of a job
  localparam logic [STEP_W-1:0] STEP_ONE_SAMPLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_TWO_SAMPLES = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ONE_TRIPLE  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_TWO_TRIPLES = 3'd5;

  typedef enum logic {
    JOB_SAMPLES,
    JOB_BYTES
  } job_kind_e;

  typedef struct packed {
    logic [1:0]        sample_format;
    logic              stereo;
    logic              swap_bytes;
    logic              little_endian;
    logic [DATA_W-1:0] xor_mask;
  } cfg_t;

  // one frame's (or one sixteen-bit sample's) worth of output work, handed from front to back
  typedef struct packed {
    job_kind_e         kind;
    logic              two;         // second sample or byte triple follows
    logic              first_last;  // first sample closes the frame
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] v0;
    logic [DATA_W-1:0] v1;
  } job_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // the back always sends bits [15:8], [23:16], [31:24]; big order swaps the outer two
  function automatic logic [31:0] byte_order(input logic [31:0] v, input logic little);
    return little ? v : {v[15:8], v[23:16], v[31:24], v[7:0]};
  endfunction

endpackage

// File: rtl/pcmu_if.sv
// handshake channel interfaces for the pcm sample word unpacker
// word input, result output and configuration write; no dependencies
interface pcmu_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface pcmu_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  logic [1:0]  data_size;
  logic        last_of_frame;

  modport source (output valid, output data, output data_size, output last_of_frame,
                  input ready);
  modport sink (input valid, input data, input data_size, input last_of_frame,
                output ready);
endinterface

interface pcmu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/pcmu_front.sv
// front end: accepts fifo words, tracks frame phase, builds output jobs
// depends on pcmu_pkg
module pcmu_front import pcmu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  input  logic [WORD_W-1:0] in_word_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output job_t              job_o
);

  logic [1:0]        phase_q, phase_d;
  logic [WORD_W-1:0] first_q, first_d;
  logic [WORD_W-1:0] second_q, second_d;
  logic              is_16;
  logic              needs_job;
  logic              accept;
  logic [15:0]       s16;
  logic [31:0]       left, right, mono;

  assign is_16     = (cfg_i.sample_format == FMT_16);
  assign needs_job = is_16 ? ((phase_q == 2'd0) || cfg_i.stereo) : phase_q[1];
  assign in_ready_o = !needs_job || !q_full_i;
  assign accept    = in_valid_i && in_ready_o;
  assign push_o    = accept && needs_job;

  always_comb begin
    s16   = in_word_i ^ cfg_i.xor_mask[15:0];
    s16   = cfg_i.swap_bytes ? swap16(s16) : s16;
    left  = {second_q[7:0], first_q, 8'h00} ^ cfg_i.xor_mask;
    right = {in_word_i, second_q[15:8], 8'h00} ^ cfg_i.xor_mask;
    mono  = {first_q, second_q[7:0], 8'h00} ^ {16'h0000, cfg_i.xor_mask[15:0]};
  end

  // job contents
  always_comb begin
    job_o.kind       = JOB_SAMPLES;
    job_o.two        = 1'b0;
    job_o.first_last = 1'b1;
    job_o.size       = SIZE_16;
    job_o.v0         = {16'h0000, s16};
    job_o.v1         = '0;
    if (is_16) begin
      job_o.first_last = (phase_q != 2'd0) || !cfg_i.stereo;
    end else if (cfg_i.sample_format == FMT_PACKED) begin
      job_o.kind = JOB_BYTES;
      job_o.size = SIZE_BYTE;
      job_o.two  = cfg_i.stereo;
      job_o.v0   = byte_order(cfg_i.stereo ? left : mono, cfg_i.little_endian);
      job_o.v1   = byte_order(right, cfg_i.little_endian);
    end else begin
      job_o.size       = SIZE_32;
      job_o.two        = cfg_i.stereo;
      job_o.first_last = !cfg_i.stereo;
      job_o.v0         = cfg_i.swap_bytes ? swap32(left) : left;
      job_o.v1         = cfg_i.swap_bytes ? swap32(right) : right;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    if (accept) begin
      if (is_16) begin
        phase_d = (phase_q == 2'd0) ? 2'd1 : 2'd0;
      end else begin
        case (phase_q)
          2'd0: begin
            first_d = in_word_i;
            phase_d = 2'd1;
          end
          2'd1: begin
            second_d = in_word_i;
            phase_d  = 2'd2;
          end
          default: phase_d = 2'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 2'd0;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// File: rtl/pcmu_queue.sv
// short job queue between front and back
// depends on pcmu_pkg
module pcmu_queue import pcmu_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/pcmu_back.sv
// back end: steps through queued jobs, one result word per cycle while the output is ready
// depends on pcmu_pkg
module pcmu_back import pcmu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o,
  output logic [SIZE_W-1:0] out_size_o,
  output logic              out_last_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] final_step;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic              last_q, last_d;
  logic              advance;
  logic [DATA_W-1:0] res_data;
  logic              res_last;

  always_comb begin
    if (job_i.kind == JOB_BYTES) begin
      final_step = job_i.two ? STEP_TWO_TRIPLES : STEP_ONE_TRIPLE;
    end else begin
      final_step = job_i.two ? STEP_TWO_SAMPLES : STEP_ONE_SAMPLE;
    end
  end

  // result for the current step of the head job
  always_comb begin
    res_data = job_i.v0;
    res_last = (step_q == final_step);
    if (job_i.kind == JOB_BYTES) begin
      case (step_q)
        3'd0:    res_data = {24'h0, job_i.v0[15:8]};
        3'd1:    res_data = {24'h0, job_i.v0[23:16]};
        3'd2:    res_data = {24'h0, job_i.v0[31:24]};
        3'd3:    res_data = {24'h0, job_i.v1[15:8]};
        3'd4:    res_data = {24'h0, job_i.v1[23:16]};
        default: res_data = {24'h0, job_i.v1[31:24]};
      endcase
    end else begin
      res_data = (step_q == STEP_ONE_SAMPLE) ? job_i.v0 : job_i.v1;
      res_last = (step_q == STEP_ONE_SAMPLE) ? job_i.first_last : 1'b1;
    end
  end

  assign advance = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && (step_q == final_step);

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    data_d      = data_q;
    size_d      = size_q;
    last_d      = last_q;
    if (advance) begin
      step_d      = pop_o ? '0 : step_q + STEP_W'(1);
      out_valid_d = 1'b1;
      data_d      = res_data;
      size_d      = job_i.size;
      last_d      = res_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    size_q <= size_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = data_q;
  assign out_size_o  = size_q;
  assign out_last_o  = last_q;

endmodule

// File: rtl/pcm_sample_word_unpacker.sv
// top level of the pcm sample word unpacker
// depends on pcmu_pkg, pcmu_if, pcmu_front, pcmu_queue and pcmu_back
//
// Rebuilds pcm samples from 16-bit codec fifo words. The front takes one word
// per cycle, keeps the first two words of a frame and, when a frame (or a
// sixteen-bit sample) is complete, pushes a job holding the masked, swapped or
// byte-ordered samples into a QUEUE_DEPTH entry queue. The back sends one
// result word per cycle from the head job while the output is ready, through a
// single output register. A word is taken every cycle while the queue has
// room, so the sustained rate is set by the result register: one word per
// cycle for sixteen-bit and thirty-two-bit frames, less for stereo packed
// three-byte frames (six bytes per three words). A frame's job goes
// through the queue and the output register. Configuration is written through
// cfg_i, always ready; writes to indexes beyond the register list are dropped.
module pcm_sample_word_unpacker import pcmu_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcmu_cfg_if.sink   cfg_i,
  pcmu_word_if.sink  in_i,
  pcmu_result_if.source out_o
);

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // front to queue to back
  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, head_job;

  assign cfg_i.ready = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FORMAT: cfg_d.sample_format = cfg_i.wdata[1:0];
        REG_STEREO: cfg_d.stereo        = cfg_i.wdata[0];
        REG_SWAP:   cfg_d.swap_bytes    = cfg_i.wdata[0];
        REG_LITTLE: cfg_d.little_endian = cfg_i.wdata[0];
        REG_MASK:   cfg_d.xor_mask      = cfg_i.wdata;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format <= FMT_16;
      cfg_q.stereo        <= 1'b0;
      cfg_q.swap_bytes    <= 1'b0;
      cfg_q.little_endian <= 1'b1;
      cfg_q.xor_mask      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // word intake and frame assembly
  pcmu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_word_i  (in_i.word),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  // decouples word intake from result delivery
  pcmu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  // result sequencing
  pcmu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data),
    .out_size_o  (out_o.data_size),
    .out_last_o  (out_o.last_of_frame)
  );

endmodule
